>>> hdl/ufsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ufsc_pkg
// Shared constants and types of the delimited frame receiver with sum check.
// ----------------------------------------------------------------------------
package ufsc_pkg;

   localparam int FRAME_BYTES = 32;
   localparam int IDX_W       = $clog2(FRAME_BYTES);
   localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
   localparam int RAM_ADDR_W  = IDX_W + 1;
   localparam int RAM_DEPTH   = 2 ** RAM_ADDR_W;

   localparam int CMDQ_DEPTH  = 2;
   localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

   localparam int OFIFO_DEPTH = 4;
   localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
   localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_CHAR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_CHAR   = 1'd1;

   localparam logic [7:0] START_CHAR_RESET = 8'd35;
   localparam logic [7:0] END_CHAR_RESET   = 8'd42;

   typedef struct packed {
      logic bank;
      logic bad;
   } cmd_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [4:0] byte_index;
      logic       last;
      logic       status;
   } rsp_type;

endpackage
`default_nettype wire

>>> hdl/ufsc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ufsc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ufsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hdl/ufsc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ufsc_front
// Accepts received bytes, tracks frame sync, stores bytes into the frame
// buffer and checks the sum when a frame closes.
// ----------------------------------------------------------------------------
module ufsc_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_push,
   output      logic                             req_full,
   input  wire logic [7:0]                       req_rx_byte,
   input  wire logic                             csr_write_en,
   input  wire logic [ufsc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [7:0]                       csr_wdata,
   input  wire logic                             cmdq_full,
   output      logic                             cmdq_push,
   output      ufsc_pkg::cmd_type                cmdq_cmd,
   output      logic                             ram_wr_en,
   output      logic [ufsc_pkg::RAM_ADDR_W-1:0]  ram_wr_addr,
   output      logic [7:0]                       ram_wr_data
);

   localparam int CNT_W = ufsc_pkg::CNT_W;
   localparam int IDX_W = ufsc_pkg::IDX_W;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ufsc_pkg::FRAME_BYTES);
   localparam logic [CNT_W-1:0] LO_CNT   = CNT_W'(ufsc_pkg::FRAME_BYTES - 2);
   localparam logic [CNT_W-1:0] HI_CNT   = CNT_W'(ufsc_pkg::FRAME_BYTES - 1);

   logic             in_frame_ff, in_frame_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      sum_ff, sum_in;
   logic [7:0]       ck_lo_ff, ck_lo_in;
   logic [7:0]       ck_hi_ff, ck_hi_in;
   logic             bank_ff, bank_in;
   logic [7:0]       start_ff, start_in;
   logic [7:0]       end_ff, end_in;
   logic             accept;
   logic             bad;

   assign req_full = cmdq_full;
   assign accept   = req_push && !cmdq_full;
   assign bad      = {ck_hi_ff, ck_lo_ff} != sum_ff;

   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      ck_lo_in    = ck_lo_ff;
      ck_hi_in    = ck_hi_ff;
      bank_in     = bank_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      cmdq_push   = 1'b0;
      cmdq_cmd    = '{bank: bank_ff, bad: bad};
      ram_wr_en   = 1'b0;
      ram_wr_addr = {bank_ff, count_ff[IDX_W-1:0]};
      ram_wr_data = req_rx_byte;

      if (csr_write_en && csr_index == ufsc_pkg::CSR_START_CHAR) begin
         start_in = csr_wdata;
      end
      if (csr_write_en && csr_index == ufsc_pkg::CSR_END_CHAR) begin
         end_in = csr_wdata;
      end

      if (accept) begin
         if (!in_frame_ff) begin
            if (req_rx_byte == start_ff) begin
               in_frame_in = 1'b1;
               count_in    = '0;
               sum_in      = '0;
            end
         end else if (req_rx_byte != start_ff && req_rx_byte == end_ff &&
                      count_ff == FULL_CNT) begin
            in_frame_in = 1'b0;
            count_in    = '0;
            cmdq_push   = 1'b1;
            if (!bad) begin
               bank_in = !bank_ff;
            end
         end else if (count_ff < FULL_CNT) begin
            ram_wr_en = 1'b1;
            count_in  = count_ff + CNT_W'(1);
            if (count_ff < LO_CNT) begin
               sum_in = sum_ff + 16'(req_rx_byte);
            end
            if (count_ff == LO_CNT) begin
               ck_lo_in = req_rx_byte;
            end
            if (count_ff == HI_CNT) begin
               ck_hi_in = req_rx_byte;
            end
         end else begin
            in_frame_in = 1'b0;
            count_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
         bank_ff     <= 1'b0;
         start_ff    <= ufsc_pkg::START_CHAR_RESET;
         end_ff      <= ufsc_pkg::END_CHAR_RESET;
      end else begin
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
         bank_ff     <= bank_in;
         start_ff    <= start_in;
         end_ff      <= end_in;
      end
      sum_ff   <= sum_in;
      ck_lo_ff <= ck_lo_in;
      ck_hi_ff <= ck_hi_in;
   end

endmodule
`default_nettype wire

>>> hdl/ufsc_cmd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ufsc_cmd_queue
// Short queue of closed frame commands between the front and the back part.
// ----------------------------------------------------------------------------
module ufsc_cmd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ufsc_pkg::cmd_type push_cmd,
   output      logic              full,
   output      logic              valid,
   output      ufsc_pkg::cmd_type head_cmd,
   input  wire logic              pop
);

   localparam int PTR_W = ufsc_pkg::CMDQ_PTR_W;
   localparam int CNT_W = ufsc_pkg::CMDQ_CNT_W;

   ufsc_pkg::cmd_type entry_ff [ufsc_pkg::CMDQ_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full     = count_ff == CNT_W'(ufsc_pkg::CMDQ_DEPTH);
   assign valid    = count_ff != '0;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(ufsc_pkg::CMDQ_DEPTH - 1)) ? '0
                   : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(ufsc_pkg::CMDQ_DEPTH - 1)) ? '0
                   : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

>>> hdl/ufsc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ufsc_back
// Carries out closed frame commands: reads a checked frame out of its buffer
// bank or produces the error item, and queues results for the result port.
// ----------------------------------------------------------------------------
module ufsc_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             cmd_valid,
   input  wire ufsc_pkg::cmd_type                cmd,
   output      logic                             cmd_pop,
   output      logic [ufsc_pkg::RAM_ADDR_W-1:0]  ram_rd_addr,
   input  wire logic [7:0]                       ram_rd_data,
   output      logic                             rsp_empty,
   input  wire logic                             rsp_pop,
   output      ufsc_pkg::rsp_type                rsp
);

   localparam int IDX_W = ufsc_pkg::IDX_W;
   localparam int PTR_W = ufsc_pkg::OFIFO_PTR_W;
   localparam int OCNT_W = ufsc_pkg::OFIFO_CNT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ufsc_pkg::FRAME_BYTES - 1);

   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_err_ff, s1_err_in;
   logic              s1_last_ff, s1_last_in;
   logic [IDX_W-1:0]  s1_idx_ff, s1_idx_in;

   ufsc_pkg::rsp_type fifo_ff [ufsc_pkg::OFIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [OCNT_W-1:0] count_ff, count_in;
   logic              space;
   logic              issue;
   logic              fifo_push;
   logic              fifo_pop;
   ufsc_pkg::rsp_type push_item;

   assign space = (OCNT_W + 1)'(count_ff) + (OCNT_W + 1)'(s1_valid_ff)
                < (OCNT_W + 1)'(ufsc_pkg::OFIFO_DEPTH);
   assign issue       = cmd_valid && space;
   assign ram_rd_addr = {cmd.bank, rd_idx_ff};
   assign fifo_push   = s1_valid_ff;
   assign fifo_pop    = rsp_pop && !rsp_empty;
   assign rsp_empty   = count_ff == '0;
   assign rsp         = fifo_ff[rd_ptr_ff];

   always_comb begin
      push_item.data_byte  = s1_err_ff ? 8'd0 : ram_rd_data;
      push_item.byte_index = s1_err_ff ? 5'd0 : 5'(s1_idx_ff);
      push_item.last       = s1_last_ff;
      push_item.status     = s1_err_ff;
   end

   always_comb begin
      rd_idx_in   = rd_idx_ff;
      s1_valid_in = issue;
      s1_err_in   = cmd.bad;
      s1_last_in  = cmd.bad || rd_idx_ff == LAST_IDX;
      s1_idx_in   = rd_idx_ff;
      cmd_pop     = 1'b0;
      if (issue) begin
         if (cmd.bad || rd_idx_ff == LAST_IDX) begin
            cmd_pop   = 1'b1;
            rd_idx_in = '0;
         end else begin
            rd_idx_in = rd_idx_ff + IDX_W'(1);
         end
      end

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (fifo_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(ufsc_pkg::OFIFO_DEPTH - 1)) ? '0
                   : wr_ptr_ff + PTR_W'(1);
      end
      if (fifo_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(ufsc_pkg::OFIFO_DEPTH - 1)) ? '0
                   : rd_ptr_ff + PTR_W'(1);
      end
      if (fifo_push && !fifo_pop) begin
         count_in = count_ff + OCNT_W'(1);
      end else if (fifo_pop && !fifo_push) begin
         count_in = count_ff - OCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff   <= '0;
         s1_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         rd_idx_ff   <= rd_idx_in;
         s1_valid_ff <= s1_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
      s1_err_ff  <= s1_err_in;
      s1_last_ff <= s1_last_in;
      s1_idx_ff  <= s1_idx_in;
      if (fifo_push) begin
         fifo_ff[wr_ptr_ff] <= push_item;
      end
   end

   // The result queue never takes an item while it is full.
   assert property (@(posedge clock) disable iff (reset)
      fifo_push && !fifo_pop |-> count_ff != OCNT_W'(ufsc_pkg::OFIFO_DEPTH))
      else $error("result queue overflow");

   // A command is retired only while one is waiting.
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command retired from an empty queue");

   // The error item is always the final item of its frame.
   assert property (@(posedge clock) disable iff (reset)
      issue && cmd.bad |=> s1_valid_ff && s1_last_ff && s1_err_ff)
      else $error("error item without last mark");

   // The read index is rewound to zero after each command.
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> rd_idx_ff == '0)
      else $error("read index not rewound after a frame");

endmodule
`default_nettype wire

>>> hdl/uart_frame_receiver_sum_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uart_frame_receiver_sum_check
// Delimited frame receiver: syncs on a start byte, buffers a frame of
// FRAME_BYTES bytes, checks the 16-bit additive sum and emits the frame or
// one checksum-error item.
// ----------------------------------------------------------------------------
// A closed frame's command passes through the command queue, the read stage
// and the result queue before its first result is on the result ports.
// Throughput: one input item per cycle and one result per cycle while the
// result port is popped; input stalls only while two closed frames wait in
// the command queue, set by the two buffer banks of the frame RAM.
// Reset: synchronous; clears sync, counters, queues and the character
// registers; the frame RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module uart_frame_receiver_sum_check (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output      logic                           req_full,
   input  wire logic [7:0]                     req_rx_byte,
   output      logic                           rsp_empty,
   input  wire logic                           rsp_pop,
   output      logic [7:0]                     rsp_data_byte,
   output      logic [4:0]                     rsp_byte_index,
   output      logic                           rsp_last,
   output      logic                           rsp_status,
   input  wire logic                           csr_write_en,
   input  wire logic [ufsc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [7:0]                     csr_wdata
);

   logic                            cmdq_full;
   logic                            cmdq_push;
   ufsc_pkg::cmd_type               cmdq_cmd;
   logic                            cmdq_valid;
   ufsc_pkg::cmd_type               cmdq_head;
   logic                            cmdq_pop;
   logic                            ram_wr_en;
   logic [ufsc_pkg::RAM_ADDR_W-1:0] ram_wr_addr;
   logic [7:0]                      ram_wr_data;
   logic [ufsc_pkg::RAM_ADDR_W-1:0] ram_rd_addr;
   logic [7:0]                      ram_rd_data;
   ufsc_pkg::rsp_type               rsp;

   ufsc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_rx_byte (req_rx_byte),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmdq_full   (cmdq_full),
      .cmdq_push   (cmdq_push),
      .cmdq_cmd    (cmdq_cmd),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   ufsc_ram #(
      .WIDTH(8),
      .DEPTH(ufsc_pkg::RAM_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   ufsc_cmd_queue u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmdq_push),
      .push_cmd(cmdq_cmd),
      .full    (cmdq_full),
      .valid   (cmdq_valid),
      .head_cmd(cmdq_head),
      .pop     (cmdq_pop)
   );

   ufsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmdq_valid),
      .cmd        (cmdq_head),
      .cmd_pop    (cmdq_pop),
      .ram_rd_addr(ram_rd_addr),
      .ram_rd_data(ram_rd_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp        (rsp)
   );

   assign rsp_data_byte  = rsp.data_byte;
   assign rsp_byte_index = rsp.byte_index;
   assign rsp_last       = rsp.last;
   assign rsp_status     = rsp.status;

endmodule
`default_nettype wire
